### src/atwt_pkg.sv
// shared types and constants for the ack timeout wheel tracker
`default_nettype none

package atwt_pkg;

  localparam int unsigned KEY_W     = 64;
  localparam int unsigned OP_W      = 3;
  localparam int unsigned CFG_W     = 7;
  localparam int unsigned CNT_OUT_W = 6;
  localparam int unsigned TDATA_W   = 72;
  localparam int unsigned TUSER_W   = 2;

  typedef enum logic [OP_W-1:0] {
    OP_ADD    = 3'd0,
    OP_REMOVE = 3'd1,
    OP_TICK   = 3'd2,
    OP_RMUP   = 3'd3,
    OP_CLEAR  = 3'd4
  } op_e;

endpackage

`default_nettype wire

### src/atwt_ram.sv
// single write port, single registered read port entry memory
`default_nettype none

module atwt_ram #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned WIDTH = 70
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

### src/ack_timeout_wheel_tracker.sv
// top level of the ack timeout wheel tracker
//
// usage: commands enter on the s_axis channel, tuser[2:0] carries the op
// (add, remove, tick, remove up to key, clear) and tdata carries the key.
// results leave on the m_axis channel, one per command, or one per expired
// key for a tick, with tlast on the final result of the command.
// every result carries the tracked key count in tdata[69:64].
// the table is an entry ram with one write port and one registered read port,
// scanned one entry a cycle by one shared 64-bit comparator.
// add, remove and remove up to each take one scan; clear and
// unknown ops give their result on the next cycle. a tick marks its slot in
// one scan, then runs one minimum search scan per expired key, and results
// come out in ascending key order.
// s_axis_tready is high only while no command is in flight and the result
// register is free or being taken; a stalled receiver holds the block.
// reset empties the table, sets the oldest slot to 0 and slot count to 2.
// a cfg write sets slot count and restarts the wheel with an empty table.
`default_nettype none

module ack_timeout_wheel_tracker
  import atwt_pkg::*;
#(
  parameter int unsigned CAPACITY  = 32,
  parameter int unsigned MAX_SLOTS = 64
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CFG_W-1:0]   cfg_wdata_i,
  input  wire logic               s_axis_tvalid_i,
  output logic                    s_axis_tready_o,
  input  wire logic [KEY_W-1:0]   s_axis_tdata_i,   // msg_key
  input  wire logic [OP_W-1:0]    s_axis_tuser_i,   // op
  output logic                    m_axis_tvalid_o,
  input  wire logic               m_axis_tready_i,
  output logic [TDATA_W-1:0]      m_axis_tdata_o,   // expired_key, tracked_count
  output logic [TUSER_W-1:0]      m_axis_tuser_o,   // ok, expired_valid
  output logic                    m_axis_tlast_o
);

  localparam int unsigned IDX_W   = $clog2(CAPACITY);
  localparam int unsigned CNT_W   = $clog2(CAPACITY + 1);
  localparam int unsigned CNT_EXT = (CNT_W > CNT_OUT_W) ? CNT_W : CNT_OUT_W;
  localparam int unsigned SLOT_W  = (MAX_SLOTS > 2) ? $clog2(MAX_SLOTS) : 1;
  localparam int unsigned ENT_W   = KEY_W + SLOT_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    P_FIND,
    P_RMUP,
    P_MARK,
    P_MIN
  } pass_e;

  state_e              state_q;
  pass_e               pass_q;
  logic                is_add_q;
  logic [KEY_W-1:0]    key_q;
  logic [CFG_W-1:0]    slot_cnt_q;
  logic [SLOT_W-1:0]   oldest_q;
  logic [CAPACITY-1:0] valid_q;
  logic [CAPACITY-1:0] pend_q;
  logic [CNT_W-1:0]    count_q;
  logic [CNT_W-1:0]    pend_cnt_q;
  logic [IDX_W:0]      addr_q;
  logic                s_vld_q;
  logic [IDX_W-1:0]    s_idx_q;
  logic                found_q;
  logic [IDX_W-1:0]    hit_idx_q;
  logic                have_min_q;
  logic [KEY_W-1:0]    min_key_q;
  logic [IDX_W-1:0]    min_idx_q;

  logic                out_vld_q;
  logic                out_ok_q;
  logic                out_ev_q;
  logic [KEY_W-1:0]    out_key_q;
  logic                out_last_q;
  logic [CNT_W-1:0]    out_cnt_q;

  logic [CFG_W-1:0]    n_eff;
  logic [SLOT_W-1:0]   newest_slot;
  logic [SLOT_W-1:0]   next_oldest;
  logic                out_free;
  logic                in_acc;
  logic                scan_end;
  logic [ENT_W-1:0]    ram_rdata;
  logic [KEY_W-1:0]    rd_key;
  logic [SLOT_W-1:0]   rd_slot;
  logic [KEY_W-1:0]    cmp_b;
  logic                cmp_lt;
  logic                cmp_eq;
  logic [IDX_W-1:0]    free_idx;
  logic                add_ok;
  logic                ram_we;
  logic [CNT_EXT-1:0]  cnt_ext;

  always_comb begin
    if (slot_cnt_q < CFG_W'(2)) begin
      n_eff = CFG_W'(2);
    end else if (slot_cnt_q > CFG_W'(MAX_SLOTS)) begin
      n_eff = CFG_W'(MAX_SLOTS);
    end else begin
      n_eff = slot_cnt_q;
    end
  end

  assign newest_slot = (oldest_q == '0) ? SLOT_W'(n_eff - CFG_W'(1)) : oldest_q - SLOT_W'(1);
  assign next_oldest = (CFG_W'(oldest_q) == n_eff - CFG_W'(1)) ? '0 : oldest_q + SLOT_W'(1);

  // shared comparator
  assign rd_key  = ram_rdata[KEY_W-1:0];
  assign rd_slot = ram_rdata[KEY_W +: SLOT_W];
  assign cmp_b   = (pass_q == P_MIN) ? min_key_q : key_q;
  assign cmp_lt  = rd_key < cmp_b;
  assign cmp_eq  = rd_key == cmp_b;

  always_comb begin
    free_idx = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_idx = IDX_W'(i);
      end
    end
  end

  assign add_ok   = !found_q && (count_q < CNT_W'(CAPACITY));
  assign out_free = !out_vld_q || m_axis_tready_i;
  assign in_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign scan_end = (addr_q == (IDX_W + 1)'(CAPACITY)) && !s_vld_q;
  assign ram_we   = (state_q == ST_DONE) && (pass_q == P_FIND) && is_add_q && add_ok
                    && out_free;

  atwt_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (ENT_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (free_idx),
    .wdata_i ({newest_slot, key_q}),
    .raddr_i (addr_q[IDX_W-1:0]),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      pass_q     <= P_FIND;
      is_add_q   <= 1'b0;
      key_q      <= '0;
      slot_cnt_q <= CFG_W'(2);
      oldest_q   <= '0;
      valid_q    <= '0;
      pend_q     <= '0;
      count_q    <= '0;
      pend_cnt_q <= '0;
      addr_q     <= '0;
      s_vld_q    <= 1'b0;
      s_idx_q    <= '0;
      found_q    <= 1'b0;
      hit_idx_q  <= '0;
      have_min_q <= 1'b0;
      min_key_q  <= '0;
      min_idx_q  <= '0;
      out_vld_q  <= 1'b0;
      out_ok_q   <= 1'b0;
      out_ev_q   <= 1'b0;
      out_key_q  <= '0;
      out_last_q <= 1'b0;
      out_cnt_q  <= '0;
    end else begin
      if (out_vld_q && m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            key_q      <= s_axis_tdata_i;
            addr_q     <= '0;
            s_vld_q    <= 1'b0;
            found_q    <= 1'b0;
            have_min_q <= 1'b0;
            case (op_e'(s_axis_tuser_i))
              OP_ADD: begin
                is_add_q <= 1'b1;
                pass_q   <= P_FIND;
                state_q  <= ST_SCAN;
              end
              OP_REMOVE: begin
                is_add_q <= 1'b0;
                pass_q   <= P_FIND;
                state_q  <= ST_SCAN;
              end
              OP_TICK: begin
                pass_q     <= P_MARK;
                pend_q     <= '0;
                pend_cnt_q <= '0;
                state_q    <= ST_SCAN;
              end
              OP_RMUP: begin
                pass_q  <= P_RMUP;
                state_q <= ST_SCAN;
              end
              OP_CLEAR: begin
                valid_q    <= '0;
                count_q    <= '0;
                out_vld_q  <= 1'b1;
                out_ok_q   <= 1'b1;
                out_ev_q   <= 1'b0;
                out_key_q  <= '0;
                out_last_q <= 1'b1;
                out_cnt_q  <= '0;
              end
              default: begin
                out_vld_q  <= 1'b1;
                out_ok_q   <= 1'b0;
                out_ev_q   <= 1'b0;
                out_key_q  <= '0;
                out_last_q <= 1'b1;
                out_cnt_q  <= count_q;
              end
            endcase
          end
        end

        ST_SCAN: begin
          // read issue
          if (addr_q != (IDX_W + 1)'(CAPACITY)) begin
            s_vld_q <= 1'b1;
            s_idx_q <= addr_q[IDX_W-1:0];
            addr_q  <= addr_q + (IDX_W + 1)'(1);
          end else begin
            s_vld_q <= 1'b0;
          end
          // compare stage
          if (s_vld_q) begin
            case (pass_q)
              P_FIND: begin
                if (valid_q[s_idx_q] && cmp_eq) begin
                  found_q   <= 1'b1;
                  hit_idx_q <= s_idx_q;
                end
              end
              P_RMUP: begin
                if (valid_q[s_idx_q] && (cmp_lt || cmp_eq)) begin
                  valid_q[s_idx_q] <= 1'b0;
                  count_q          <= count_q - CNT_W'(1);
                end
              end
              P_MARK: begin
                if (valid_q[s_idx_q] && (rd_slot == oldest_q)) begin
                  valid_q[s_idx_q] <= 1'b0;
                  pend_q[s_idx_q]  <= 1'b1;
                  count_q          <= count_q - CNT_W'(1);
                  pend_cnt_q       <= pend_cnt_q + CNT_W'(1);
                end
              end
              P_MIN: begin
                if (pend_q[s_idx_q] && (!have_min_q || cmp_lt)) begin
                  have_min_q <= 1'b1;
                  min_key_q  <= rd_key;
                  min_idx_q  <= s_idx_q;
                end
              end
              default: begin
              end
            endcase
          end
          if (scan_end) begin
            state_q <= ST_DONE;
          end
        end

        ST_DONE: begin
          if (out_free) begin
            out_ev_q   <= 1'b0;
            out_key_q  <= '0;
            out_last_q <= 1'b1;
            out_ok_q   <= 1'b1;
            out_cnt_q  <= count_q;
            state_q    <= ST_IDLE;
            case (pass_q)
              P_FIND: begin
                out_vld_q <= 1'b1;
                if (is_add_q) begin
                  out_ok_q <= add_ok;
                  if (add_ok) begin
                    valid_q[free_idx] <= 1'b1;
                    count_q           <= count_q + CNT_W'(1);
                    out_cnt_q         <= count_q + CNT_W'(1);
                  end
                end else begin
                  out_ok_q <= found_q;
                  if (found_q) begin
                    valid_q[hit_idx_q] <= 1'b0;
                    count_q            <= count_q - CNT_W'(1);
                    out_cnt_q          <= count_q - CNT_W'(1);
                  end
                end
              end
              P_RMUP: begin
                out_vld_q <= 1'b1;
              end
              P_MARK: begin
                oldest_q <= next_oldest;
                if (pend_cnt_q == '0) begin
                  out_vld_q <= 1'b1;
                end else begin
                  pass_q     <= P_MIN;
                  addr_q     <= '0;
                  have_min_q <= 1'b0;
                  state_q    <= ST_SCAN;
                end
              end
              P_MIN: begin
                out_vld_q         <= 1'b1;
                out_ev_q          <= 1'b1;
                out_key_q         <= min_key_q;
                out_last_q        <= (pend_cnt_q == CNT_W'(1));
                pend_q[min_idx_q] <= 1'b0;
                pend_cnt_q        <= pend_cnt_q - CNT_W'(1);
                if (pend_cnt_q != CNT_W'(1)) begin
                  addr_q     <= '0;
                  have_min_q <= 1'b0;
                  state_q    <= ST_SCAN;
                end
              end
              default: begin
              end
            endcase
          end
        end

        default: begin
          state_q <= ST_IDLE;
        end
      endcase

      // wheel restart on a slot count write
      if (cfg_we_i) begin
        slot_cnt_q <= cfg_wdata_i;
        valid_q    <= '0;
        pend_q     <= '0;
        count_q    <= '0;
        oldest_q   <= '0;
      end
    end
  end

  assign cnt_ext = CNT_EXT'(out_cnt_q);

  assign s_axis_tready_o = (state_q == ST_IDLE) && out_free;
  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {(TDATA_W - KEY_W - CNT_OUT_W)'(0), cnt_ext[CNT_OUT_W-1:0], out_key_q};
  assign m_axis_tuser_o  = {out_ev_q, out_ok_q};
  assign m_axis_tlast_o  = out_last_q;

endmodule

`default_nettype wire

### sim/ack_timeout_wheel_tracker_tb.sv
// self-checking testbench for the ack timeout wheel tracker
`timescale 1ns / 100ps

module ack_timeout_wheel_tracker_tb;
  import atwt_pkg::*;

  localparam int unsigned CAPACITY  = 32;
  localparam int unsigned MAX_SLOTS = 64;
  localparam int unsigned LIMIT     = 1_000_000;
  localparam logic [OP_W-1:0] OP_BAD_FIRST = 3'd5;
  localparam logic [OP_W-1:0] OP_BAD_LAST  = 3'd7;
  localparam logic [KEY_W-1:0] KEY_MAX = {KEY_W{1'b1}};

  typedef struct {
    logic [OP_W-1:0]  op;
    logic [KEY_W-1:0] key;
  } cmd_t;

  typedef struct {
    logic                 ok;
    logic                 expired_valid;
    logic [KEY_W-1:0]     expired_key;
    logic                 last;
    logic [CNT_OUT_W-1:0] tracked_count;
  } result_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_W-1:0]     cfg_wdata_i = '0;
  logic                 s_axis_tvalid_i = 1'b0;
  logic                 s_axis_tready_o;
  logic [KEY_W-1:0]     s_axis_tdata_i = '0;
  logic [OP_W-1:0]      s_axis_tuser_i = '0;
  logic                 m_axis_tvalid_o;
  logic                 m_axis_tready_i = 1'b0;
  logic [TDATA_W-1:0]   m_axis_tdata_o;
  logic [TUSER_W-1:0]   m_axis_tuser_o;
  logic                 m_axis_tlast_o;

  cmd_t        queued_cmds[$];
  result_t     pending_results[$];
  int unsigned send_idle = 0;
  int unsigned recv_idle = 0;
  int unsigned err_count = 0;
  int unsigned cycle_cnt = 0;
  logic [KEY_W-1:0] key_pool[48];

  // tracker state as seen by the checker
  bit               tbl_valid[CAPACITY];
  logic [KEY_W-1:0] tbl_key[CAPACITY];
  int unsigned      tbl_slot[CAPACITY];
  int unsigned      head_slot = 0;
  int unsigned      live_count = 0;
  int unsigned      slots_raw = 2;

  ack_timeout_wheel_tracker #(
    .CAPACITY (CAPACITY),
    .MAX_SLOTS(MAX_SLOTS)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic int unsigned wheel_slots();
    if (slots_raw < 2) return 2;
    if (slots_raw > MAX_SLOTS) return MAX_SLOTS;
    return slots_raw;
  endfunction

  function automatic void expect_result(logic ok, logic ev, logic [KEY_W-1:0] key, logic last);
    result_t r;
    r.ok = ok;
    r.expired_valid = ev;
    r.expired_key = key;
    r.last = last;
    r.tracked_count = live_count[CNT_OUT_W-1:0];
    pending_results.insert(pending_results.size(), r);
  endfunction

  function automatic void empty_tracker();
    for (int i = 0; i < CAPACITY; i++) tbl_valid[i] = 0;
    live_count = 0;
  endfunction

  function automatic int find_entry(logic [KEY_W-1:0] key);
    for (int i = 0; i < CAPACITY; i++)
      if (tbl_valid[i] && tbl_key[i] == key) return i;
    return -1;
  endfunction

  function automatic void apply_tracker_cmd(logic [OP_W-1:0] op, logic [KEY_W-1:0] key);
    int unsigned n;
    int unsigned oldest;
    int          hit;
    bit          due[CAPACITY];
    int          due_cnt;
    int          pick;
    logic        ok;
    n = wheel_slots();
    oldest = head_slot % n;
    ok = 1'b0;
    case (op)
      OP_ADD: begin
        if (find_entry(key) < 0 && live_count < CAPACITY) begin
          for (int i = 0; i < CAPACITY; i++) begin
            if (!tbl_valid[i]) begin
              tbl_valid[i] = 1;
              tbl_key[i] = key;
              tbl_slot[i] = (oldest + n - 1) % n;
              live_count++;
              ok = 1'b1;
              break;
            end
          end
        end
        expect_result(ok, 1'b0, '0, 1'b1);
      end
      OP_REMOVE: begin
        hit = find_entry(key);
        if (hit >= 0) begin
          tbl_valid[hit] = 0;
          live_count--;
        end
        expect_result(hit >= 0, 1'b0, '0, 1'b1);
      end
      OP_TICK: begin
        due_cnt = 0;
        for (int i = 0; i < CAPACITY; i++) begin
          due[i] = tbl_valid[i] && tbl_slot[i] == oldest;
          if (due[i]) begin
            tbl_valid[i] = 0;
            live_count--;
            due_cnt++;
          end
        end
        head_slot = (oldest + 1) % n;
        if (due_cnt == 0) expect_result(1'b1, 1'b0, '0, 1'b1);
        // expired keys leave in ascending unsigned order
        for (int k = 0; k < due_cnt; k++) begin
          pick = -1;
          for (int i = 0; i < CAPACITY; i++)
            if (due[i] && (pick < 0 || tbl_key[i] < tbl_key[pick])) pick = i;
          due[pick] = 0;
          expect_result(1'b1, 1'b1, tbl_key[pick], k == due_cnt - 1);
        end
      end
      OP_RMUP: begin
        for (int i = 0; i < CAPACITY; i++) begin
          if (tbl_valid[i] && tbl_key[i] <= key) begin
            tbl_valid[i] = 0;
            live_count--;
          end
        end
        expect_result(1'b1, 1'b0, '0, 1'b1);
      end
      OP_CLEAR: begin
        empty_tracker();
        expect_result(1'b1, 1'b0, '0, 1'b1);
      end
      default: expect_result(1'b0, 1'b0, '0, 1'b1);
    endcase
  endfunction

  function automatic void check_field(string name, logic [KEY_W-1:0] want, logic [KEY_W-1:0] got);
    if (want !== got) begin
      err_count++;
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
    end
  endfunction

  // driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_o) apply_tracker_cmd(s_axis_tuser_i, s_axis_tdata_i);
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (queued_cmds.size() != 0 && $urandom_range(99) >= send_idle) begin
          s_axis_tvalid_i <= 1'b1;
          s_axis_tuser_i  <= queued_cmds[0].op;
          s_axis_tdata_i  <= queued_cmds[0].key;
          queued_cmds.delete(0);
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= $urandom_range(99) >= recv_idle;
    end
  end

  // monitor
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_results.size() == 0) begin
        err_count++;
        $display("%0t: unexpected result, expected none actual tdata %0h tuser %0h", $time,
                 m_axis_tdata_o, m_axis_tuser_o);
      end else begin
        want = pending_results[0];
        pending_results.delete(0);
        check_field("ok", KEY_W'(want.ok), KEY_W'(m_axis_tuser_o[0]));
        check_field("expired_valid", KEY_W'(want.expired_valid), KEY_W'(m_axis_tuser_o[1]));
        check_field("expired_key", want.expired_key, m_axis_tdata_o[KEY_W-1:0]);
        check_field("last", KEY_W'(want.last), KEY_W'(m_axis_tlast_o));
        check_field("tracked_count", KEY_W'(want.tracked_count),
                    KEY_W'(m_axis_tdata_o[KEY_W +: CNT_OUT_W]));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic push_cmd(logic [OP_W-1:0] op, logic [KEY_W-1:0] key);
    cmd_t c;
    c.op = op;
    c.key = key;
    queued_cmds.insert(queued_cmds.size(), c);
  endtask

  function automatic logic [KEY_W-1:0] any_key();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [KEY_W-1:0] pick_key();
    if ($urandom_range(99) < 85) return key_pool[$urandom_range(47)];
    return any_key();
  endfunction

  task automatic wait_idle();
    do @(negedge clk_i);
    while (queued_cmds.size() != 0 || s_axis_tvalid_i || pending_results.size() != 0);
    repeat (CAPACITY + 8) @(posedge clk_i);
  endtask

  task automatic set_wheel(int unsigned v);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v[CFG_W-1:0];
    slots_raw = v[CFG_W-1:0];
    empty_tracker();
    head_slot = 0;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic queue_random(int count);
    int unsigned r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      if (r < 42) push_cmd(OP_ADD, pick_key());
      else if (r < 66) push_cmd(OP_TICK, any_key());
      else if (r < 78) push_cmd(OP_REMOVE, pick_key());
      else if (r < 86) push_cmd(OP_RMUP, pick_key());
      else if (r < 90) push_cmd(OP_CLEAR, any_key());
      else if (r < 95) push_cmd(OP_W'($urandom_range(OP_BAD_FIRST, OP_BAD_LAST)), any_key());
      else push_cmd(OP_ADD, any_key());
    end
  endtask

  initial begin
    int unsigned wheel_plan[8];
    wheel_plan = '{0, 3, 127, 1, 0, 65, 64, 2};
    wheel_plan[4] = $urandom_range(4, 12);
    for (int i = 0; i < 48; i++) key_pool[i] = any_key();
    key_pool[0] = '0;
    key_pool[1] = KEY_MAX;
    key_pool[2] = {1'b1, {(KEY_W-1){1'b0}}};
    empty_tracker();
    send_idle = 37;
    recv_idle = 68;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed, two slot wheel after reset
    push_cmd(OP_ADD, '0);
    push_cmd(OP_ADD, KEY_MAX);
    push_cmd(OP_ADD, '0);
    push_cmd(OP_REMOVE, 64'd5);
    push_cmd(OP_REMOVE, KEY_MAX);
    push_cmd(OP_ADD, {1'b1, {(KEY_W-1){1'b0}}});
    push_cmd(OP_ADD, KEY_MAX);
    push_cmd(OP_TICK, '0);
    push_cmd(OP_TICK, KEY_MAX);
    push_cmd(OP_TICK, '0);
    push_cmd(OP_ADD, 64'd1);
    push_cmd(OP_ADD, 64'd2);
    push_cmd(OP_ADD, {1'b0, {(KEY_W-1){1'b1}}});
    push_cmd(OP_RMUP, 64'd1);
    push_cmd(OP_RMUP, '0);
    push_cmd(OP_RMUP, KEY_MAX);
    push_cmd(OP_ADD, 64'd10);
    push_cmd(OP_ADD, 64'd11);
    push_cmd(OP_CLEAR, '0);
    push_cmd(OP_BAD_FIRST, any_key());
    push_cmd(OP_W'(OP_BAD_FIRST + 1), any_key());
    push_cmd(OP_BAD_LAST, KEY_MAX);
    push_cmd(OP_REMOVE, 64'd10);
    wait_idle();

    for (int p = 0; p < 8; p++) begin
      if (p == 3) begin
        send_idle = 68;
        recv_idle = 37;
      end else if (p == 6) begin
        send_idle = 0;
        recv_idle = 0;
      end
      set_wheel(wheel_plan[p]);
      if (p == 1) begin
        // overfill the table, then tick through the wheel so everything expires in the last tick
        for (int i = 0; i < CAPACITY + 1; i++) push_cmd(OP_ADD, any_key());
        push_cmd(OP_ADD, any_key());
        repeat (3) push_cmd(OP_TICK, any_key());
        queue_random(15);
      end else begin
        queue_random(p >= 5 && p <= 6 ? 15 : 20);
      end
      wait_idle();
    end

    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### sim.f
src/atwt_pkg.sv
src/atwt_ram.sv
src/ack_timeout_wheel_tracker.sv
sim/ack_timeout_wheel_tracker_tb.sv
